// ===== hw/rtl/bfba_pkg.sv =====
// Shared types and constants for the best-fit block allocator.
// Used by bfba_cell and best_fit_block_allocator_unit; no dependencies.
package bfba_pkg;

    // Default configuration
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed field widths of the transaction ports
    localparam int KIND_W   = 2;
    localparam int INSIZE_W = 16;
    localparam int STATUS_W = 2;
    localparam int OUTIDX_W = 4;
    localparam int LEFT_W   = 16;
    localparam int SUM_W    = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNASSIGNED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

    // Per-cell command strobes from the controller
    typedef struct packed {
        logic wr;     // load a new block size, mark it free
        logic mark;   // set the used mark
        logic clear;  // free the block
    } t_cell_ctl;

    // Control bits of the search token passed down the chain
    typedef struct packed {
        logic valid;  // token present in this stage
        logic found;  // some fitting block seen so far
    } t_tok;

endpackage

// ===== hw/rtl/bfba_cell.sv =====
// One allocator cell: holds one block size with its loaded and used marks,
// and refines the best-fit search token on its way down the chain. Uses bfba_pkg.
module bfba_cell #(
    parameter int SIZE_BITS = bfba_pkg::SIZE_BITS_DEF,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bfba_pkg::t_cell_ctl   i_ctl,
    input  logic [SIZE_BITS-1:0]  i_wdata,
    input  logic [SIZE_BITS-1:0]  i_req,
    input  bfba_pkg::t_tok        i_tok,
    input  logic [SIZE_BITS-1:0]  i_tok_left,
    input  logic [IDX_W-1:0]      i_tok_idx,
    output bfba_pkg::t_tok        o_tok,
    output logic [SIZE_BITS-1:0]  o_tok_left,
    output logic [IDX_W-1:0]      o_tok_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_loaded;
    logic                 r_used;
    bfba_pkg::t_tok       r_tok;
    logic [SIZE_BITS-1:0] r_tok_left;
    logic [IDX_W-1:0]     r_tok_idx;

    logic                 fits;
    logic [SIZE_BITS-1:0] my_left;
    logic                 take;

    // Store the block size on load
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_size <= i_wdata;
        end
    end

    // Track loaded and used marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_used   <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_loaded <= 1'b1;
            end
            if (i_ctl.wr || i_ctl.clear) begin
                r_used <= 1'b0;
            end else if (i_ctl.mark) begin
                r_used <= 1'b1;
            end
        end
    end

    // Compare this block against the best candidate so far
    always_comb begin
        fits    = r_loaded && !r_used && (i_req <= r_size);
        my_left = r_size - i_req;
        take    = fits && (!i_tok.found || (my_left < i_tok_left));
    end

    // Advance the token to the next cell; earlier index wins on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_tok.found <= i_tok.found || fits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_left <= take ? my_left : i_tok_left;
        r_tok_idx  <= take ? MY_IDX  : i_tok_idx;
    end

    assign o_tok      = r_tok;
    assign o_tok_left = r_tok_left;
    assign o_tok_idx  = r_tok_idx;

endmodule

// ===== hw/rtl/best_fit_block_allocator_unit.sv =====
// Best-fit block allocator top level: controller, running totals and the cell chain.
// Depends on bfba_pkg and bfba_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction of kind and size.
//   Kind load appends a block size, kind allocate searches for the free block with
//   the smallest leftover (lowest index on a tie), kind clear frees every block and
//   zeroes both totals; the unused kind only reports the current totals.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result per input:
//   status, block index, leftover and the saturating internal and external totals.
// Sequence of work:
//   Load, clear and the unused kind: the controller moves straight to its finish
//   state, from which the result is registered into the output register.
//   Allocate: a search token walks the chain of MAX_BLOCKS cells, one cell per
//   cycle; when it leaves the last cell the controller captures the result and
//   moves from scan to finish state, from which the result goes to the output register.
//   One transaction is in work at a time; the next one is taken once the result
//   has moved into the output register, which frees the input while it waits.
// Reset (synchronous, active low) empties the block table, frees all blocks and
//   zeroes both totals; the unit is ready in the first cycle after reset.
// When the receiver stalls, the result holds in the output register; a second
//   finished result waits in the controller until the register frees.
module best_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS = bfba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = bfba_pkg::SIZE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bfba_pkg::KIND_W-1:0]     i_kind,
    input  logic [bfba_pkg::INSIZE_W-1:0]   i_size,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bfba_pkg::STATUS_W-1:0]   o_status,
    output logic [bfba_pkg::OUTIDX_W-1:0]   o_block_index,
    output logic [bfba_pkg::LEFT_W-1:0]     o_leftover,
    output logic [bfba_pkg::SUM_W-1:0]      o_internal_total,
    output logic [bfba_pkg::SUM_W-1:0]      o_external_total
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);
    localparam int SUM_W = bfba_pkg::SUM_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;
    logic [SIZE_BITS-1:0] r_req;
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_int_sum;
    logic [SUM_W-1:0]     r_ext_sum;
    logic                 r_start;

    // Pending result waiting for the output register
    logic [bfba_pkg::STATUS_W-1:0] r_res_status;
    logic [IDX_W-1:0]              r_res_idx;
    logic [SIZE_BITS-1:0]          r_res_left;

    // Output register
    logic                          r_out_valid;
    logic [bfba_pkg::STATUS_W-1:0] r_out_status;
    logic [bfba_pkg::OUTIDX_W-1:0] r_out_index;
    logic [bfba_pkg::LEFT_W-1:0]   r_out_left;
    logic [SUM_W-1:0]              r_out_int;
    logic [SUM_W-1:0]              r_out_ext;

    // Token chain
    bfba_pkg::t_tok       tok      [MAX_BLOCKS+1];
    logic [SIZE_BITS-1:0] tok_left [MAX_BLOCKS+1];
    logic [IDX_W-1:0]     tok_idx  [MAX_BLOCKS+1];
    bfba_pkg::t_cell_ctl  cell_ctl [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] mark_vec;

    logic                 in_acc;
    logic                 out_free;
    logic                 load_go;
    logic                 clear_go;
    logic                 scan_end;
    logic                 is_full;
    logic [31:0]          size_ext;
    logic [SIZE_BITS-1:0] req_in;
    logic [SUM_W:0]       int_add;
    logic [SUM_W:0]       ext_add;
    logic [31:0]          idx_ext;
    logic [31:0]          left_ext;

    // Decode the incoming transaction
    always_comb begin
        in_acc   = i_in_valid && (r_state == S_IDLE);
        out_free = !r_out_valid || !i_out_stall;
        size_ext = {16'd0, i_size};
        req_in   = size_ext[SIZE_BITS-1:0];
        is_full  = (r_count == CNT_FULL);
        load_go  = in_acc && (i_kind == bfba_pkg::KIND_LOAD) && !is_full;
        clear_go = in_acc && (i_kind == bfba_pkg::KIND_CLEAR);
        scan_end = tok[MAX_BLOCKS].valid;
        int_add  = {1'b0, r_int_sum} + (SUM_W + 1)'(tok_left[MAX_BLOCKS]);
        ext_add  = {1'b0, r_ext_sum} + (SUM_W + 1)'(r_req);
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Launch the token and broadcast commands to the cells
    assign tok[0]      = '{valid: r_start, found: 1'b0};
    assign tok_left[0] = '0;
    assign tok_idx[0]  = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        assign mark_vec[g] = scan_end && tok[MAX_BLOCKS].found
                             && (tok_idx[MAX_BLOCKS] == IDX_W'(g));
        assign cell_ctl[g] = '{wr:    load_go && (r_count == CNT_W'(g)),
                               mark:  mark_vec[g],
                               clear: clear_go};

        bfba_cell #(
            .SIZE_BITS (SIZE_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl[g]),
            .i_wdata    (req_in),
            .i_req      (r_req),
            .i_tok      (tok[g]),
            .i_tok_left (tok_left[g]),
            .i_tok_idx  (tok_idx[g]),
            .o_tok      (tok[g+1]),
            .o_tok_left (tok_left[g+1]),
            .o_tok_idx  (tok_idx[g+1])
        );
    end

    // Controller: state, block count, totals and start pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_int_sum <= '0;
            r_ext_sum <= '0;
            r_start   <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_kind == bfba_pkg::KIND_ALLOC) begin
                            r_start <= 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                        if (load_go) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (clear_go) begin
                            r_int_sum <= '0;
                            r_ext_sum <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_end) begin
                        r_state <= S_FIN;
                        if (tok[MAX_BLOCKS].found) begin
                            r_int_sum <= int_add[SUM_W] ? '1 : int_add[SUM_W-1:0];
                        end else begin
                            r_ext_sum <= ext_add[SUM_W] ? '1 : ext_add[SUM_W-1:0];
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture the request and build the pending result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req        <= req_in;
            r_res_idx    <= '0;
            r_res_left   <= '0;
            r_res_status <= (i_kind == bfba_pkg::KIND_LOAD && is_full)
                            ? bfba_pkg::ST_FULL : bfba_pkg::ST_OK;
        end else if (r_state == S_SCAN && scan_end) begin
            if (tok[MAX_BLOCKS].found) begin
                r_res_status <= bfba_pkg::ST_OK;
                r_res_idx    <= tok_idx[MAX_BLOCKS];
                r_res_left   <= tok_left[MAX_BLOCKS];
            end else begin
                r_res_status <= bfba_pkg::ST_UNASSIGNED;
                r_res_idx    <= '0;
                r_res_left   <= '0;
            end
        end
    end

    // Output register: load when the pending result may move, drop on handoff
    always_comb begin
        idx_ext  = 32'(r_res_idx);
        left_ext = 32'(r_res_left);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_status <= r_res_status;
            r_out_index  <= idx_ext[bfba_pkg::OUTIDX_W-1:0];
            r_out_left   <= left_ext[bfba_pkg::LEFT_W-1:0];
            r_out_int    <= r_int_sum;
            r_out_ext    <= r_ext_sum;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_block_index    = r_out_index;
    assign o_leftover       = r_out_left;
    assign o_internal_total = r_out_int;
    assign o_external_total = r_out_ext;

    // At most one block is marked used per search
    a_mark_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(mark_vec))
        else $error("more than one cell marked used");

    // The search token only leaves the chain while scanning
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[MAX_BLOCKS].valid |-> (r_state == S_SCAN))
        else $error("search token outside a scan");

    // The block count never passes the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("block count beyond table depth");

    // An accepted transaction blocks the input on the following cycle
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transaction accepted while one is in work");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for best_fit_block_allocator_unit.
// Predicts each best-fit result in SystemVerilog and checks every output transaction.
// Depends on bfba_pkg and the allocator RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = bfba_pkg::MAX_BLOCKS_DEF;
    localparam int KIND_W       = bfba_pkg::KIND_W;
    localparam int SIZE_W       = bfba_pkg::INSIZE_W;
    localparam int STATUS_W     = bfba_pkg::STATUS_W;
    localparam int IDX_W        = bfba_pkg::OUTIDX_W;
    localparam int LEFT_W       = bfba_pkg::LEFT_W;
    localparam int SUM_W        = bfba_pkg::SUM_W;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 400;
    localparam int MAX_REPORTS  = 100;

    // Kind with no defined operation; the unit only reports the totals
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] size;
    } t_alloc_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    block_index;
        logic [LEFT_W-1:0]   leftover;
        logic [SUM_W-1:0]    internal_total;
        logic [SUM_W-1:0]    external_total;
    } t_alloc_result;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind = KIND_SPARE;
    logic [SIZE_W-1:0]     i_size = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [IDX_W-1:0]      o_block_index;
    logic [LEFT_W-1:0]     o_leftover;
    logic [SUM_W-1:0]      o_internal_total;
    logic [SUM_W-1:0]      o_external_total;

    // Predicted allocator state
    logic [SIZE_W-1:0]     table_size [TABLE_DEPTH];
    logic                  table_used [TABLE_DEPTH];
    int                    table_count = 0;
    logic [SUM_W-1:0]      internal_frag = '0;
    logic [SUM_W-1:0]      external_frag = '0;

    // Stimulus and scoreboard
    t_alloc_req            pending_items [$];
    t_alloc_result         expected_results [$];
    logic [SIZE_W-1:0]     loaded_sizes [$];
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    logic                  hold_go = 1'b0;
    logic                  long_hold = 1'b0;
    int                    phase_items = 0;

    int                    error_count = 0;
    int                    accepted_count = 0;
    int                    checked_count = 0;
    int                    unassigned_count = 0;
    int                    full_count = 0;

    best_fit_block_allocator_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_size           (i_size),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_block_index    (o_block_index),
        .o_leftover       (o_leftover),
        .o_internal_total (o_internal_total),
        .o_external_total (o_external_total)
    );

    // 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SIZE_W-1:0] b);
        logic [SUM_W:0] wide;
        wide = {1'b0, a} + (SUM_W + 1)'(b);
        return wide[SUM_W] ? '1 : wide[SUM_W-1:0];
    endfunction

    // Advance the predicted state by one transaction and return its result
    function automatic t_alloc_result predict_allocation(t_alloc_req req);
        t_alloc_result     res;
        logic              found;
        logic [SIZE_W-1:0] slack;
        logic [SIZE_W-1:0] best_slack;
        int                best;
        res = '0;
        res.status = bfba_pkg::ST_OK;
        case (req.kind)
            bfba_pkg::KIND_LOAD: begin
                if (table_count < TABLE_DEPTH) begin
                    table_size[table_count] = req.size;
                    table_used[table_count] = 1'b0;
                    table_count++;
                end else begin
                    res.status = bfba_pkg::ST_FULL;
                end
            end
            bfba_pkg::KIND_ALLOC: begin
                found = 1'b0;
                best = 0;
                best_slack = '0;
                // Scan every loaded, free block; strict compare keeps the lowest index on a tie
                for (int i = 0; i < table_count; i++) begin
                    if (!table_used[i] && req.size <= table_size[i]) begin
                        slack = table_size[i] - req.size;
                        if (!found || slack < best_slack) begin
                            found = 1'b1;
                            best = i;
                            best_slack = slack;
                        end
                    end
                end
                if (found) begin
                    table_used[best] = 1'b1;
                    internal_frag = sat_add(internal_frag, best_slack);
                    res.block_index = IDX_W'(best);
                    res.leftover = best_slack;
                end else begin
                    external_frag = sat_add(external_frag, req.size);
                    res.status = bfba_pkg::ST_UNASSIGNED;
                end
            end
            bfba_pkg::KIND_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) table_used[i] = 1'b0;
                internal_frag = '0;
                external_frag = '0;
            end
            default: ;
        endcase
        res.internal_total = internal_frag;
        res.external_total = external_frag;
        return res;
    endfunction

    function automatic void check_field(string field, logic [SUM_W-1:0] want,
                                        logic [SUM_W-1:0] got);
        if (want !== got) begin
            if (error_count < MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    // Driver: predict on acceptance, then offer the next pending transaction or idle
    always @(posedge i_clk) begin : drive_input
        t_alloc_req taken;
        t_alloc_req item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                taken.kind = i_kind;
                taken.size = i_size;
                expected_results.push_back(predict_allocation(taken));
                accepted_count++;
            end
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = pending_items.pop_front();
                i_in_valid <= 1'b1;
                i_kind <= item.kind;
                i_size <= item.size;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction, then pick the stall
    always @(posedge i_clk) begin : check_output
        t_alloc_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $error("result with no transaction outstanding: status %0d", o_status);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", SUM_W'(want.status), SUM_W'(o_status));
                    check_field("block_index", SUM_W'(want.block_index),
                                SUM_W'(o_block_index));
                    check_field("leftover", SUM_W'(want.leftover), SUM_W'(o_leftover));
                    check_field("internal_total", want.internal_total, o_internal_total);
                    check_field("external_total", want.external_total, o_external_total);
                    checked_count++;
                    case (want.status)
                        bfba_pkg::ST_UNASSIGNED: unassigned_count++;
                        bfba_pkg::ST_FULL:       full_count++;
                        default: ;
                    endcase
                end
            end
            i_out_stall <= long_hold || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Long receiver hold: fill the unit until it stalls its input
    initial begin : receiver_hold
        do @(posedge i_clk); while (!hold_go);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic push_item(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size);
        t_alloc_req item;
        item.kind = kind;
        item.size = size;
        pending_items.push_back(item);
        if (kind == bfba_pkg::KIND_LOAD && loaded_sizes.size() < TABLE_DEPTH)
            loaded_sizes.push_back(size);
        phase_items++;
    endtask

    function automatic logic [SIZE_W-1:0] pick_block_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8) return SIZE_W'($urandom_range(1, 255));
        if (r < 16 || loaded_sizes.size() == 0) return SIZE_W'($urandom_range(0, 65535));
        if (r < 18) return loaded_sizes[$urandom_range(0, loaded_sizes.size() - 1)];
        if (r == 18) return '0;
        return '1;
    endfunction

    // Requests cluster around loaded sizes: exact fits, near fits and just-too-large
    function automatic logic [SIZE_W-1:0] pick_request();
        int                r;
        logic [SIZE_W-1:0] base;
        if (loaded_sizes.size() == 0) return SIZE_W'($urandom_range(0, 65535));
        base = loaded_sizes[$urandom_range(0, loaded_sizes.size() - 1)];
        r = $urandom_range(0, 99);
        if (r < 40) return base;
        if (r < 65) return (base > 16) ? base - SIZE_W'($urandom_range(0, 16))
                                       : SIZE_W'($urandom_range(0, base));
        if (r < 75) return base + 1'b1;
        if (r < 90) return SIZE_W'($urandom_range(0, 65535));
        if (r < 95) return '0;
        return '1;
    endfunction

    // One session: grow the table while it has room, usually clear, then a run of requests
    task automatic queue_session();
        int                n;
        logic [KIND_W-1:0] noise_kind;
        if (loaded_sizes.size() < TABLE_DEPTH) push_item(bfba_pkg::KIND_LOAD, pick_block_size());
        if ($urandom_range(0, 9) != 0)
            push_item(bfba_pkg::KIND_CLEAR, SIZE_W'($urandom_range(0, 65535)));
        n = $urandom_range(1, 20);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) begin
                noise_kind = KIND_W'($urandom_range(0, 3));
                push_item(noise_kind, SIZE_W'($urandom_range(0, 65535)));
            end
            push_item(bfba_pkg::KIND_ALLOC, pick_request());
        end
    endtask

    // Hold off the sender until every transaction has come back
    task automatic wait_quiet();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int send_idle_by_phase [4];
        int recv_stall_by_phase [4];
        send_idle_by_phase  = '{0, 79, 0, 11};
        recv_stall_by_phase = '{0, 0, 79, 11};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, spare kind, extremes, ties, exhaustion and clear
        push_item(bfba_pkg::KIND_ALLOC, 16'd5);
        push_item(KIND_SPARE, 16'hFFFF);
        push_item(bfba_pkg::KIND_LOAD, 16'd0);
        push_item(bfba_pkg::KIND_LOAD, 16'hFFFF);
        push_item(bfba_pkg::KIND_LOAD, 16'd100);
        push_item(bfba_pkg::KIND_LOAD, 16'd100);
        push_item(bfba_pkg::KIND_LOAD, 16'd300);
        push_item(bfba_pkg::KIND_ALLOC, 16'd100);
        push_item(bfba_pkg::KIND_ALLOC, 16'd100);
        push_item(bfba_pkg::KIND_ALLOC, 16'd100);
        push_item(bfba_pkg::KIND_ALLOC, 16'd0);
        push_item(bfba_pkg::KIND_ALLOC, 16'hFFFF);
        push_item(bfba_pkg::KIND_ALLOC, 16'd1);
        push_item(bfba_pkg::KIND_CLEAR, 16'h5A5A);
        push_item(bfba_pkg::KIND_ALLOC, 16'd50);
        push_item(bfba_pkg::KIND_ALLOC, 16'd0);
        push_item(bfba_pkg::KIND_ALLOC, 16'hFFFF);
        push_item(bfba_pkg::KIND_ALLOC, 16'd301);
        push_item(KIND_SPARE, 16'h0000);
        push_item(bfba_pkg::KIND_CLEAR, 16'h0000);
        wait_quiet();

        // Random sessions under each idling mode
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            if (p == 0) hold_go = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) queue_session();
            wait_quiet();
        end

        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d predicted results never arrived", expected_results.size());
            error_count++;
        end
        $display("Checked %0d results for %0d transactions: %0d unassigned, %0d table-full loads.",
                 checked_count, accepted_count, unassigned_count, full_count);
        $display("Covered directed corner cases, four idling modes and a long output hold.");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run
    initial begin : run_limit
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
